>>> design/dle_pkg.sv
// Shared constants and types for the DLE/STX/ETX deframer.
// No dependencies; imported by every module of the block except dle_fifo.
package dle_pkg;

  localparam int STORE_DEPTH_DEFAULT = 64;
  localparam int BODY_START          = 2;
  localparam int MIN_CLOSE_INDEX     = 4;

  localparam logic [7:0] SYM_DLE = 8'h10;
  localparam logic [7:0] SYM_STX = 8'h02;
  localparam logic [7:0] SYM_ETX = 8'h03;

  localparam logic [5:0] BODY_LIMIT_MAX = 6'd59;
  localparam logic [5:0] LIMIT_RESET    = 6'd31;

  typedef struct packed {
    logic valid;
    logic bank;
  } done_t;

endpackage

>>> design/dle_fifo.sv
// Two-entry frame descriptor queue between front and back.
// Depends on nothing beyond its WIDTH parameter.
module dle_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_pop,
  output logic             empty,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] slots [2];
  logic             wptr;
  logic             rptr;
  logic [1:0]       count;
  logic             push;

  assign empty   = (count == 2'd0);
  assign push    = wr_valid && (count != 2'd2);
  assign rd_data = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (rd_pop && !empty) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, push} - {1'b0, rd_pop && !empty};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= wr_data;
    end
  end

endmodule

>>> design/dle_store.sv
// Two-bank frame store: one write port, one registered read port.
// Uses dle_pkg for the default depth.
module dle_store
  import dle_pkg::*;
#(
  parameter int STORE_DEPTH = STORE_DEPTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [$clog2(STORE_DEPTH):0]     wr_addr,
  input  logic [7:0]                       wr_data,
  input  logic                             rd_en,
  input  logic [$clog2(STORE_DEPTH):0]     rd_addr,
  output logic [7:0]                       rd_data
);

  logic [7:0] mem [2**($clog2(STORE_DEPTH)+1)];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> design/dle_front.sv
// Front part: unstuffs received bytes, fills the current bank, checks frames.
// Uses dle_pkg symbols and done_t; feeds dle_store and dle_fifo.
module dle_front
  import dle_pkg::*;
#(
  parameter int STORE_DEPTH = STORE_DEPTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_byte,
  input  logic                            cfg_we,
  input  logic [5:0]                      cfg_value,
  input  done_t                           done,
  output logic                            wr_en,
  output logic [$clog2(STORE_DEPTH):0]    wr_addr,
  output logic [7:0]                      wr_data,
  output logic                            push,
  output logic [$clog2(STORE_DEPTH)+1:0]  push_desc
);

  localparam int AW   = $clog2(STORE_DEPTH);
  localparam int IDXW = AW + 1;
  localparam int CMPW = (IDXW > 6) ? IDXW : 6;

  logic [5:0]      limit;
  logic            pend, pend_next;
  logic [IDXW-1:0] widx, widx_next, widx_inc, body_len;
  logic [7:0]      sum, sum_next, last1, last1_next, last2, last2_next;
  logic            bank, bank_next;
  logic [1:0]      busy, busy_next;
  logic            accept, store_req, close_ok;
  logic [5:0]      eff_limit;

  assign in_ready  = !busy[bank];
  assign accept    = in_valid && in_ready;
  assign widx_inc  = widx + IDXW'(1);
  assign body_len  = widx - IDXW'(MIN_CLOSE_INDEX);
  assign eff_limit = (limit > BODY_LIMIT_MAX) ? BODY_LIMIT_MAX : limit;
  assign close_ok  = (widx >= IDXW'(MIN_CLOSE_INDEX))
                   && (CMPW'(body_len) <= CMPW'(eff_limit))
                   && ((sum - SYM_DLE - last2) == last2);

  assign wr_addr   = {bank, widx[AW-1:0]};
  assign wr_data   = in_byte;
  assign push_desc = {bank, widx - IDXW'(3)};

  always_comb begin
    pend_next  = pend;
    widx_next  = widx;
    sum_next   = sum;
    last1_next = last1;
    last2_next = last2;
    bank_next  = bank;
    busy_next  = busy;
    push       = 1'b0;
    wr_en      = 1'b0;
    store_req  = 1'b0;
    if (done.valid) begin
      busy_next[done.bank] = 1'b0;
    end
    if (accept) begin
      pend_next = 1'b0;
      if (in_byte == SYM_DLE) begin
        if (!pend) begin
          pend_next = 1'b1;
          store_req = 1'b1;
        end
      end else if (pend && in_byte == SYM_STX) begin
        widx_next = IDXW'(BODY_START);
        sum_next  = 8'd0;
      end else if (pend && in_byte == SYM_ETX) begin
        widx_next = '0;
        if (close_ok) begin
          push            = 1'b1;
          busy_next[bank] = 1'b1;
          bank_next       = ~bank;
        end
      end else begin
        store_req = 1'b1;
      end
      if (store_req && widx >= IDXW'(BODY_START)) begin
        wr_en      = 1'b1;
        widx_next  = widx_inc;
        sum_next   = sum + in_byte;
        last1_next = in_byte;
        last2_next = last1;
        if (widx_inc == IDXW'(STORE_DEPTH)) begin
          widx_next = '0;
          pend_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
      pend  <= 1'b0;
      widx  <= '0;
      bank  <= 1'b0;
      busy  <= 2'b00;
    end else begin
      if (cfg_we) begin
        limit <= cfg_value;
      end
      pend <= pend_next;
      widx <= widx_next;
      bank <= bank_next;
      busy <= busy_next;
    end
  end

  always_ff @(posedge clk) begin
    sum   <= sum_next;
    last1 <= last1_next;
    last2 <= last2_next;
  end

endmodule

>>> design/dle_back.sv
// Back part: takes frame descriptors and streams the stored bytes out.
// Uses dle_pkg done_t; reads dle_store, pops dle_fifo.
module dle_back
  import dle_pkg::*;
#(
  parameter int STORE_DEPTH = STORE_DEPTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_empty,
  input  logic [$clog2(STORE_DEPTH)+1:0]  q_desc,
  output logic                            q_pop,
  output logic                            rd_en,
  output logic [$clog2(STORE_DEPTH):0]    rd_addr,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_last,
  output done_t                           done
);

  localparam int AW   = $clog2(STORE_DEPTH);
  localparam int IDXW = AW + 1;

  logic            active;
  logic            cur_bank;
  logic [IDXW-1:0] k, cnt, k_addr;
  logic            advance, last_item;

  assign advance   = !out_valid || out_ready;
  assign last_item = (k == cnt - IDXW'(1));
  assign q_pop     = !active && !q_empty;
  assign rd_en     = advance && active;
  assign k_addr    = k + IDXW'(BODY_START);
  assign rd_addr   = {cur_bank, k_addr[AW-1:0]};
  assign done.valid = advance && active && last_item;
  assign done.bank  = cur_bank;

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
      out_last  <= 1'b0;
    end else begin
      if (q_pop) begin
        active <= 1'b1;
      end
      if (advance) begin
        out_valid <= active;
        out_last  <= active && last_item;
        if (active && last_item) begin
          active <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_bank <= q_desc[IDXW];
      cnt      <= q_desc[IDXW-1:0];
      k        <= '0;
    end else if (rd_en) begin
      k <= k + IDXW'(1);
    end
  end

endmodule

>>> design/dle_frame_deframer_checksum.sv
// DLE/STX/ETX deframer with 8-bit additive checksum, top level.
// Input: one byte per cycle; tready drops only while both store banks hold frames
// not yet drained. Output: the closing ETX queues a descriptor, then bytes stream
// out one per cycle while m_axis_tready holds, idle between frames for a queue pop.
// Reset: synchronous, clears control and sets the body limit to 31; store undefined.
module dle_frame_deframer_checksum
  import dle_pkg::*;
#(
  parameter int STORE_DEPTH = STORE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [5:0] cfg_data        // [5:0] max_body_len
);

  localparam int AW   = $clog2(STORE_DEPTH);
  localparam int DESW = AW + 2;

  logic            wr_en, rd_en, push, q_pop, q_empty;
  logic [AW:0]     wr_addr, rd_addr;
  logic [7:0]      wr_data;
  logic [DESW-1:0] push_desc, q_desc;
  done_t           done;

  assign cfg_ready = 1'b1;

  dle_front #(.STORE_DEPTH(STORE_DEPTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_byte   (s_axis_tdata),
    .cfg_we    (cfg_valid),
    .cfg_value (cfg_data),
    .done      (done),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .push      (push),
    .push_desc (push_desc)
  );

  dle_fifo #(.WIDTH(DESW)) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (push),
    .wr_data  (push_desc),
    .rd_pop   (q_pop),
    .empty    (q_empty),
    .rd_data  (q_desc)
  );

  dle_store #(.STORE_DEPTH(STORE_DEPTH)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (m_axis_tdata)
  );

  dle_back #(.STORE_DEPTH(STORE_DEPTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_desc    (q_desc),
    .q_pop     (q_pop),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_last  (m_axis_tlast),
    .done      (done)
  );

endmodule

>>> tb/dle_frame_deframer_checksum_tb.sv
// Self-checking bench for dle_frame_deframer_checksum: directed frames from a table,
// then random framed traffic with noise; typed rows are checked against their table
// entry, the rest against a bytewise deframer model. Depends on dle_pkg and deframer RTL.
`timescale 1ns / 1ps

module dle_frame_deframer_checksum_tb;
  import dle_pkg::*;

  localparam int DEPTH = STORE_DEPTH_DEFAULT;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_beat_t;

  typedef struct {
    logic [71:0] seq;
    int          len;
    bit          typed;
    int          exp_n;
    logic [7:0]  exp_byte;
  } dir_row_t;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_e;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [5:0] cfg_data = 6'd0;

  // deframer model state
  logic [7:0] fstore [DEPTH];
  int         widx;
  bit         dle_seen;
  logic [5:0] body_limit;

  out_beat_t  closed_frame_bytes [$];
  out_beat_t  expected_bytes [$];
  out_beat_t  got;
  logic [7:0] raw_q [$];

  bit         typed_row = 1'b0;
  bit         gaps_on = 1'b1;
  int         burst_left = 0;
  rx_mode_e   rx_mode = RX_RANDOM;
  logic [7:0] stall_mask = 8'h5b;
  bit         hold_req = 1'b0;
  int         hold_left = 0;

  int n_in = 0;
  int n_out = 0;
  int n_frames = 0;
  int n_cfg = 0;
  int errors = 0;

  dir_row_t dir_rows [10] = '{
    '{72'h55_03,                   2, 1'b1, 0, 8'h00},
    '{72'h10_03,                   2, 1'b1, 0, 8'h00},
    '{72'h10_02_00_10_03,          5, 1'b1, 1, 8'h00},
    '{72'h10_02_10_03,             4, 1'b1, 0, 8'h00},
    '{72'h10_02_ff_ff_10_03,       6, 1'b0, 0, 8'h00},
    '{72'h10_02_10_10_10_10_10_03, 8, 1'b0, 0, 8'h00},
    '{72'h10_02_01_05_10_03,       6, 1'b1, 0, 8'h00},
    '{72'h10_02_55_10_02_07_07_10_03, 9, 1'b0, 0, 8'h00},
    '{72'h10_02_10_41_51_10_03,    7, 1'b0, 0, 8'h00},
    '{72'h10_10_02,                3, 1'b1, 0, 8'h00}
  };

  dle_frame_deframer_checksum dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic void keep_rx(input logic [7:0] b);
    if (widx < BODY_START) return;
    if (widx < DEPTH) fstore[widx] = b;
    widx++;
    if (widx >= DEPTH) begin
      widx = 0;
      dle_seen = 1'b0;
    end
  endfunction

  function automatic void close_frame();
    int idx;
    int body;
    int lim;
    int k;
    logic [7:0] sum;
    idx = widx;
    widx = 0;
    if (idx < MIN_CLOSE_INDEX || idx > DEPTH) return;
    body = idx - MIN_CLOSE_INDEX;
    lim = int'((body_limit > BODY_LIMIT_MAX) ? BODY_LIMIT_MAX : body_limit);
    if (body > lim) return;
    sum = 8'h00;
    for (k = 0; k < body; k++) sum += fstore[BODY_START + k];
    if (sum != fstore[idx - 2]) return;
    for (k = 0; k <= body; k++)
      closed_frame_bytes.push_back('{data: fstore[BODY_START + k], last: (k == body)});
  endfunction

  function automatic void deframe_byte(input logic [7:0] b);
    closed_frame_bytes.delete();
    if (b == SYM_DLE) begin
      if (dle_seen) begin
        dle_seen = 1'b0;
      end else begin
        dle_seen = 1'b1;
        keep_rx(b);
      end
    end else if (dle_seen && b == SYM_STX) begin
      dle_seen = 1'b0;
      widx = BODY_START;
    end else if (dle_seen && b == SYM_ETX) begin
      dle_seen = 1'b0;
      close_frame();
    end else begin
      dle_seen = 1'b0;
      keep_rx(b);
    end
  endfunction

  function automatic bit is_ctrl(input logic [7:0] b);
    return b == SYM_DLE || b == SYM_STX || b == SYM_ETX;
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return SYM_DLE;
      1: return SYM_STX;
      2: return SYM_ETX;
      3: return 8'h00;
      4: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] v;
    v = 8'($urandom);
    if (v == SYM_DLE) v = 8'h11;
    return v;
  endfunction

  // stuff body and checksum; a DLE before an ordinary byte may go unstuffed
  function automatic void build_frame(input int blen, input bit corrupt);
    logic [7:0] data [$];
    logic [7:0] sum;
    logic [7:0] v;
    int i;
    sum = 8'h00;
    for (i = 0; i < blen; i++) begin
      v = pick_byte();
      data.push_back(v);
      sum += v;
    end
    if (corrupt) sum ^= 8'h01 << $urandom_range(0, 7);
    data.push_back(sum);
    raw_q.push_back(SYM_DLE);
    raw_q.push_back(SYM_STX);
    for (i = 0; i < data.size(); i++) begin
      raw_q.push_back(data[i]);
      if (data[i] == SYM_DLE &&
          !(i + 1 < data.size() && !is_ctrl(data[i + 1]) && $urandom_range(0, 1)))
        raw_q.push_back(SYM_DLE);
    end
    raw_q.push_back(SYM_DLE);
    raw_q.push_back(SYM_ETX);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int g;
    if (gaps_on && burst_left == 0) begin
      g = $urandom_range(1, 6);
      burst_left = $urandom_range(1, 16);
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= 8'($urandom);
      repeat (g - 1) @(negedge clk);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    do @(posedge clk); while (!s_axis_tready);
    n_in++;
    deframe_byte(b);
    if (!typed_row)
      foreach (closed_frame_bytes[i]) expected_bytes.push_back(closed_frame_bytes[i]);
  endtask

  task automatic send_raw();
    foreach (raw_q[i]) send_byte(raw_q[i]);
    raw_q.delete();
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_limit(input logic [5:0] v);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    body_limit = v;
    n_cfg++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_seq();
    int r;
    int lim;
    int len;
    int i;
    lim = int'((body_limit > BODY_LIMIT_MAX) ? BODY_LIMIT_MAX : body_limit);
    r = $urandom_range(0, 99);
    if (r < 70) begin
      case ($urandom_range(0, 9))
        0, 1: len = lim;
        2:    len = lim + 1;
        default: len = $urandom_range(0, (lim < 8) ? lim : 8);
      endcase
      build_frame(len, $urandom_range(0, 9) == 0);
    end else if (r < 80) begin
      repeat ($urandom_range(1, 6)) raw_q.push_back(pick_byte());
    end else if (r < 86) begin
      raw_q.push_back(SYM_DLE);
      raw_q.push_back(SYM_STX);
      repeat ($urandom_range(1, 4)) raw_q.push_back(plain_byte());
      build_frame($urandom_range(0, (lim < 4) ? lim : 4), 1'b0);
    end else if (r < 91) begin
      raw_q.push_back(SYM_DLE);
      raw_q.push_back(SYM_STX);
      raw_q.push_back(SYM_DLE);
      raw_q.push_back(SYM_ETX);
    end else if (r < 95) begin
      raw_q.push_back(SYM_DLE);
      raw_q.push_back(SYM_ETX);
    end else if (r < 97) begin
      raw_q.push_back(SYM_DLE);
      raw_q.push_back(SYM_STX);
      for (i = 0; i < DEPTH - 2 + $urandom_range(0, 4); i++) raw_q.push_back(plain_byte());
      raw_q.push_back(SYM_DLE);
      raw_q.push_back(SYM_ETX);
    end else begin
      raw_q.push_back(SYM_DLE);
      raw_q.push_back(plain_byte());
    end
    send_raw();
  endtask

  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = 400;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS: m_axis_tready <= 1'b1;
        RX_RANDOM: m_axis_tready <= ($urandom_range(0, 3) != 0);
        default: begin
          m_axis_tready <= stall_mask[0];
          stall_mask = {stall_mask[0], stall_mask[7:1]};
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_bytes.size() == 0) begin
        $error("out_byte: no transfer expected, got %02h last %0b", m_axis_tdata, m_axis_tlast);
        errors++;
      end else begin
        got = expected_bytes.pop_front();
        if (m_axis_tdata !== got.data) begin
          $error("out_byte: expected %02h, got %02h", got.data, m_axis_tdata);
          errors++;
        end
        if (m_axis_tlast !== got.last) begin
          $error("out_last: expected %0b, got %0b", got.last, m_axis_tlast);
          errors++;
        end
      end
      n_out++;
      if (m_axis_tlast) n_frames++;
    end
  end

  initial begin
    logic [5:0] limits [6];
    int start;
    int p;
    int k;
    foreach (fstore[i]) fstore[i] = 8'h00;
    widx = 0;
    dle_seen = 1'b0;
    body_limit = LIMIT_RESET;
    limits = '{6'd0, 6'd63, 6'd1, 6'd59, 6'($urandom), 6'd31};

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      typed_row = dir_rows[i].typed;
      if (dir_rows[i].typed && dir_rows[i].exp_n == 1)
        expected_bytes.push_back('{data: dir_rows[i].exp_byte, last: 1'b1});
      for (k = 0; k < dir_rows[i].len; k++)
        send_byte(dir_rows[i].seq[8 * (dir_rows[i].len - 1 - k) +: 8]);
      typed_row = 1'b0;
    end

    // hold the output off while frames keep arriving back to back
    wait_drained();
    gaps_on = 1'b0;
    hold_req = 1'b1;
    repeat (4) begin
      build_frame(4, 1'b0);
      send_raw();
    end
    wait_drained();

    for (p = 0; p < 6; p++) begin
      write_limit(limits[p]);
      rx_mode = rx_mode_e'($urandom_range(0, 2));
      stall_mask = 8'($urandom) | 8'h01;
      gaps_on = $urandom_range(0, 3) != 0;
      if (limits[p] == BODY_LIMIT_MAX) begin
        build_frame(BODY_LIMIT_MAX, 1'b0);
        send_raw();
      end
      start = n_in;
      while (n_in - start < 14) random_seq();
    end

    wait_drained();
    repeat (20) @(posedge clk);
    $display("Sent %0d bytes over %0d limit writes; checked %0d output bytes in %0d frames",
             n_in, n_cfg, n_out, n_frames);
    if (errors == 0 && expected_bytes.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
